// ===== sv/dehf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dehf_pkg: shared types and constants of the dual EMA hysteresis filter
// Sequencer states, configuration register indexes, hysteresis decision
// record and the fixed widths of the alpha, time and configuration fields.
// ============================================================================
package dehf_pkg;

    localparam int ALPHA_BITS     = 17;
    localparam int ALPHA_SHIFT    = 16;
    localparam int HOLD_BITS      = 16;
    localparam int TIME_BITS      = 32;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [ALPHA_BITS-1:0] ALPHA_MIN = 17'd7;
    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = 17'd65536;

    localparam logic [ALPHA_BITS-1:0] ALPHA_P_RST  = 17'd6554;
    localparam logic [ALPHA_BITS-1:0] ALPHA_S_RST  = 17'd3277;
    localparam int                    THR_SMALL_RST = 5242;
    localparam int                    THR_BIG_RST   = 20966;
    localparam logic [HOLD_BITS-1:0]  HOLD_RST      = 16'd100;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ALPHA_P   = 3'd0,
        CFG_ALPHA_S   = 3'd1,
        CFG_THR_SMALL = 3'd2,
        CFG_THR_BIG   = 3'd3,
        CFG_HOLD      = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ADD1,
        ST_HYST,
        ST_MUL2,
        ST_ADD2,
        ST_DONE
    } state_t;

    // Decision of the stable/transition machine for one word.
    typedef struct packed {
        logic latch;       // copy the smoothed value into the held value
        logic stamp;       // record the current time as the change time
        logic moving_next; // transition flag after this word
    } hyst_t;

endpackage
`default_nettype wire

// ===== sv/dehf_step_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dehf_step_unit: shared EMA multiply and accumulate unit
// Registers alpha * (target - current) while mul_en is set; the next cycle adds the
// floor-shifted product to the current value and clamps to full scale.
// ============================================================================
module dehf_step_unit
    import dehf_pkg::*;
#(
    parameter int                    VALUE_BITS = 20,
    parameter logic [VALUE_BITS-1:0] FULL_SCALE = '1
)
(
    input  wire logic                  clk,
    input  wire logic                  mul_en,
    input  wire logic [ALPHA_BITS-1:0] alpha,
    input  wire logic [VALUE_BITS-1:0] target,
    input  wire logic [VALUE_BITS-1:0] current,
    output logic      [VALUE_BITS-1:0] result
);

    localparam int PROD_BITS = VALUE_BITS + ALPHA_BITS + 2;

    logic        [ALPHA_BITS-1:0] alpha_c;
    logic signed [VALUE_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [PROD_BITS-1:0]  sum;

    // Weights outside the useful range are pinned to its ends.
    always_comb
    begin
        if (alpha < ALPHA_MIN)
        begin
            alpha_c = ALPHA_MIN;
        end
        else if (alpha > ALPHA_MAX)
        begin
            alpha_c = ALPHA_MAX;
        end
        else
        begin
            alpha_c = alpha;
        end
    end

    assign diff = $signed({1'b0, target}) - $signed({1'b0, current});
    assign prod = $signed({1'b0, alpha_c}) * diff;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod;
        end
    end

    // Arithmetic shift rounds toward minus infinity.
    assign sum = $signed({{(PROD_BITS-VALUE_BITS){1'b0}}, current}) + (prod_reg >>> ALPHA_SHIFT);

    always_comb
    begin
        if (sum < 0)
        begin
            result = '0;
        end
        else if (sum > $signed({{(PROD_BITS-VALUE_BITS){1'b0}}, FULL_SCALE}))
        begin
            result = FULL_SCALE;
        end
        else
        begin
            result = sum[VALUE_BITS-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/dehf_hyst.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dehf_hyst: stable/transition decision
// Compares the smoothed value with the held value against the effective
// thresholds and checks the hold time since the last change.
// ============================================================================
module dehf_hyst
    import dehf_pkg::*;
#(
    parameter int VALUE_BITS = 20
)
(
    input  wire logic                  moving,
    input  wire logic [VALUE_BITS-1:0] smooth,
    input  wire logic [VALUE_BITS-1:0] latched,
    input  wire logic [TIME_BITS-1:0]  now,
    input  wire logic [TIME_BITS-1:0]  change_time,
    input  wire logic [HOLD_BITS-1:0]  hold,
    input  wire logic [VALUE_BITS:0]   thr_small,
    input  wire logic [VALUE_BITS:0]   thr_big,
    output hyst_t                      decision
);

    logic [VALUE_BITS:0]  delta;
    logic [TIME_BITS-1:0] elapsed;

    assign delta   = (smooth > latched) ? ({1'b0, smooth} - {1'b0, latched})
                                        : ({1'b0, latched} - {1'b0, smooth});
    assign elapsed = now - change_time;

    always_comb
    begin
        decision.latch       = 1'b0;
        decision.stamp       = 1'b0;
        decision.moving_next = moving;
        if (!moving)
        begin
            if (delta > thr_big)
            begin
                decision.latch       = 1'b1;
                decision.stamp       = 1'b1;
                decision.moving_next = 1'b1;
            end
        end
        else if (elapsed > {{(TIME_BITS-HOLD_BITS){1'b0}}, hold})
        begin
            decision.latch       = 1'b1;
            decision.moving_next = (delta > thr_small);
        end
    end

endmodule
`default_nettype wire

// ===== sv/dual_ema_hysteresis_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// dual_ema_hysteresis_filter: potentiometer smoothing with hysteresis
// Primary EMA, stable/transition hold logic and a secondary EMA, computed
// with one shared multiplier under a small sequencer.
// ============================================================================
// Usage:
// The input channel (in_valid/in_ready) takes one word: a raw sample and a
// millisecond timestamp. The output channel (out_valid/out_ready) returns one
// word per input: filtered, smoothed and held values plus the moving flag.
// The configuration channel (cfg_valid/cfg_ready) writes one register per
// word, selected by cfg_index; unknown indexes are ignored. It is always
// ready and must only be used while the filter is idle.
// Timing: a regular word runs from acceptance to out_valid through two passes
// of the shared multiplier (multiply, accumulate) with the hysteresis step
// between them; in_ready returns in the same cycle as out_valid, so a new
// word is accepted only once the previous one has left the sequencer. The
// first word after reset only loads the filter values and skips the passes.
// A finished word sits in an output register, so the next input is accepted
// and computed while the receiver stalls; the sequencer waits in its final
// state only if that register is still occupied. Reset restores the default
// register values, clears the output valid flag and marks the next word first.
// ============================================================================
module dual_ema_hysteresis_filter
    import dehf_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [SAMPLE_BITS-1:0]                sample,
    input  wire logic [TIME_BITS-1:0]                  now_ms,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [SAMPLE_BITS+FRACTION_BITS-1:0]  filtered,
    output logic      [SAMPLE_BITS+FRACTION_BITS-1:0]  smoothed,
    output logic      [SAMPLE_BITS+FRACTION_BITS-1:0]  held,
    output logic                                       moving,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]             cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]              cfg_data
);

    localparam int VALUE_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam longint FULL_SCALE_L = ((longint'(1) << SAMPLE_BITS) - 1) << FRACTION_BITS;
    localparam longint MIN_GAP_L    = (FULL_SCALE_L + 9999) / 10000;
    localparam logic [VALUE_BITS-1:0] FULL_SCALE = FULL_SCALE_L[VALUE_BITS-1:0];
    localparam logic [VALUE_BITS:0]   MIN_GAP    = MIN_GAP_L[VALUE_BITS:0];

    // Configuration registers.
    logic [ALPHA_BITS-1:0] alpha_p_reg;
    logic [ALPHA_BITS-1:0] alpha_s_reg;
    logic [VALUE_BITS-1:0] thr_small_reg;
    logic [VALUE_BITS-1:0] thr_big_reg;
    logic [HOLD_BITS-1:0]  hold_reg;

    // Sequencer and filter state.
    state_t                state_reg, state_next;
    logic                  first_reg, first_next;
    logic                  moving_reg, moving_next;
    logic [VALUE_BITS-1:0] smooth_reg, smooth_next;
    logic [VALUE_BITS-1:0] output_reg, output_next;
    logic [VALUE_BITS-1:0] latched_reg, latched_next;
    logic [TIME_BITS-1:0]  change_reg, change_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [VALUE_BITS:0]   ts_reg, ts_next;
    logic [VALUE_BITS:0]   tb_reg, tb_next;

    // Output word register.
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_filt_reg, out_filt_next;
    logic [VALUE_BITS-1:0] out_smooth_reg, out_smooth_next;
    logic [VALUE_BITS-1:0] out_held_reg, out_held_next;
    logic                  out_moving_reg, out_moving_next;

    logic                  in_fire;
    logic                  out_free;
    logic                  sel_secondary;
    logic                  mul_en;
    logic [ALPHA_BITS-1:0] step_alpha;
    logic [VALUE_BITS-1:0] step_target;
    logic [VALUE_BITS-1:0] step_current;
    logic [VALUE_BITS-1:0] step_result;
    logic [VALUE_BITS:0]   ts_eff;
    logic [VALUE_BITS:0]   tb_eff;
    hyst_t                 decision;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_p_reg   <= ALPHA_P_RST;
            alpha_s_reg   <= ALPHA_S_RST;
            thr_small_reg <= VALUE_BITS'(THR_SMALL_RST);
            thr_big_reg   <= VALUE_BITS'(THR_BIG_RST);
            hold_reg      <= HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALPHA_P:   alpha_p_reg   <= cfg_data[ALPHA_BITS-1:0];
                CFG_ALPHA_S:   alpha_s_reg   <= cfg_data[ALPHA_BITS-1:0];
                CFG_THR_SMALL: thr_small_reg <= cfg_data[VALUE_BITS-1:0];
                CFG_THR_BIG:   thr_big_reg   <= cfg_data[VALUE_BITS-1:0];
                CFG_HOLD:      hold_reg      <= cfg_data[HOLD_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Effective thresholds: the small one never below the minimum gap, the
    // big one at least the minimum gap above the small one. Registered once
    // per regular word during the first multiply.
    always_comb
    begin
        if ({1'b0, thr_small_reg} < MIN_GAP)
        begin
            ts_eff = MIN_GAP;
        end
        else
        begin
            ts_eff = {1'b0, thr_small_reg};
        end
        if ({1'b0, thr_big_reg} < ts_eff + MIN_GAP)
        begin
            tb_eff = ts_eff + MIN_GAP;
        end
        else
        begin
            tb_eff = {1'b0, thr_big_reg};
        end
    end

    // ------------------------------------------------------------------
    // Shared EMA unit: primary pass on the sample, secondary on the held value
    // ------------------------------------------------------------------
    assign sel_secondary = state_reg inside {ST_MUL2, ST_ADD2};
    assign mul_en        = state_reg inside {ST_MUL1, ST_MUL2};
    assign step_alpha    = sel_secondary ? alpha_s_reg : alpha_p_reg;
    assign step_target   = sel_secondary ? latched_reg : value_reg;
    assign step_current  = sel_secondary ? output_reg  : smooth_reg;

    dehf_step_unit #(
        .VALUE_BITS (VALUE_BITS),
        .FULL_SCALE (FULL_SCALE)
    ) u_step (
        .clk     (clk),
        .mul_en  (mul_en),
        .alpha   (step_alpha),
        .target  (step_target),
        .current (step_current),
        .result  (step_result)
    );

    dehf_hyst #(
        .VALUE_BITS (VALUE_BITS)
    ) u_hyst (
        .moving      (moving_reg),
        .smooth      (smooth_reg),
        .latched     (latched_reg),
        .now         (now_reg),
        .change_time (change_reg),
        .hold        (hold_reg),
        .thr_small   (ts_reg),
        .thr_big     (tb_reg),
        .decision    (decision)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= 1'b1;
            moving_reg     <= 1'b0;
            smooth_reg     <= '0;
            output_reg     <= '0;
            latched_reg    <= '0;
            change_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            moving_reg     <= moving_next;
            smooth_reg     <= smooth_next;
            output_reg     <= output_next;
            latched_reg    <= latched_next;
            change_reg     <= change_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        now_reg        <= now_next;
        ts_reg         <= ts_next;
        tb_reg         <= tb_next;
        out_filt_reg   <= out_filt_next;
        out_smooth_reg <= out_smooth_next;
        out_held_reg   <= out_held_next;
        out_moving_reg <= out_moving_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        moving_next     = moving_reg;
        smooth_next     = smooth_reg;
        output_next     = output_reg;
        latched_next    = latched_reg;
        change_next     = change_reg;
        value_next      = value_reg;
        now_next        = now_reg;
        ts_next         = ts_reg;
        tb_next         = tb_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_filt_next   = out_filt_reg;
        out_smooth_next = out_smooth_reg;
        out_held_next   = out_held_reg;
        out_moving_next = out_moving_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    value_next = {sample, {FRACTION_BITS{1'b0}}};
                    now_next   = now_ms;
                    if (first_reg)
                    begin
                        // The first word loads all three values directly.
                        first_next   = 1'b0;
                        smooth_next  = {sample, {FRACTION_BITS{1'b0}}};
                        output_next  = {sample, {FRACTION_BITS{1'b0}}};
                        latched_next = {sample, {FRACTION_BITS{1'b0}}};
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                ts_next    = ts_eff;
                tb_next    = tb_eff;
                state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                smooth_next = step_result;
                state_next  = ST_HYST;
            end
            ST_HYST:
            begin
                moving_next = decision.moving_next;
                if (decision.latch)
                begin
                    latched_next = smooth_reg;
                end
                if (decision.stamp)
                begin
                    change_next = now_reg;
                end
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                output_next = step_result;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_filt_next   = output_reg;
                    out_smooth_next = smooth_reg;
                    out_held_next   = latched_reg;
                    out_moving_next = moving_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign filtered  = out_filt_reg;
    assign smoothed  = out_smooth_reg;
    assign held      = out_held_reg;
    assign moving    = out_moving_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready
    ) else $error("input accepted while a word was still in progress");

    a_values_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (smoothed <= FULL_SCALE) && (filtered <= FULL_SCALE)
                      && (held <= FULL_SCALE)
    ) else $error("filter value beyond full scale");

    a_out_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && (state_reg != ST_DONE)) |=> !out_valid
    ) else $error("output word repeated without a new result");

    a_first_skips_ema: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && first_reg) |=> (state_reg == ST_DONE) && !first_reg
    ) else $error("first word did not load the filter values directly");

endmodule
`default_nettype wire
